// ===== design/psrf_pkg.sv =====
// Package for the pressure sensor register file: request and response types,
// event codes, register map addresses and the calibration ROM contents.
// No dependencies.
`default_nettype none

package psrf_pkg;

	// Number of 16-bit calibration words held in the ROM.
	localparam int CALIB_WORDS_DEF = 13;
	localparam int CALIB_WORDS_MAX = 16;

	// Event codes carried in the kind field.
	typedef enum logic [1:0] {
		KIND_I2C_WR = 2'd0,
		KIND_I2C_RD = 2'd1,
		KIND_SPI    = 2'd2,
		KIND_LOAD   = 2'd3
	} kind_t;

	// Register map addresses and fixed byte values.
	localparam logic [7:0] ID_ADDR    = 8'hD0;
	localparam logic [7:0] ID_VALUE   = 8'h58;
	localparam logic [7:0] RESET_ADDR = 8'hE0;
	localparam logic [7:0] RESET_CODE = 8'hB6;
	localparam logic [7:0] CALIB_BASE = 8'h88;
	localparam logic [7:0] PRESS_MSB  = 8'hF7;
	localparam logic [7:0] PRESS_LSB  = 8'hF8;
	localparam logic [7:0] PRESS_XLSB = 8'hF9;
	localparam logic [7:0] TEMP_MSB   = 8'hFA;
	localparam logic [7:0] TEMP_LSB   = 8'hFB;
	localparam logic [7:0] TEMP_XLSB  = 8'hFC;
	localparam logic [7:0] NO_REG     = 8'hFF;
	localparam logic [7:0] SPI_SET    = 8'h80;

	// Byte position within a transaction that carries the register pointer.
	localparam logic [7:0] I2C_PTR_POS = 8'd2;
	localparam logic [7:0] SPI_CMD_POS = 8'd1;
	localparam logic [7:0] SPI_DAT_POS = 8'd2;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_index;
		logic [7:0]  data_byte;
		logic [23:0] temp_raw;
		logic [23:0] press_raw;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
	} rsp_t;

	// Calibration ROM, 16-bit words; slack entries read zero.
	function automatic logic [15:0] calib_word(input logic [3:0] idx);
		logic [15:0] w;
		case (idx)
			4'd0:    w = 16'd27504;
			4'd1:    w = 16'd26435;
			4'd2:    w = 16'd64536;
			4'd3:    w = 16'd36477;
			4'd4:    w = 16'd54851;
			4'd5:    w = 16'd3024;
			4'd6:    w = 16'd2855;
			4'd7:    w = 16'd140;
			4'd8:    w = 16'd65529;
			4'd9:    w = 16'd15500;
			4'd10:   w = 16'd50936;
			4'd11:   w = 16'd6000;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== design/psrf_chan_if.sv =====
// Valid/ready channel interface used for requests and responses.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface psrf_chan_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/pressure_sensor_register_file_top.sv =====
// Top level of the pressure sensor register file.
// Depends on psrf_pkg and the psrf_chan_if channel interface.
`default_nettype none

// Byte-level register map of a temperature and pressure sensor. Each request
// is one bus byte event (I2C write, I2C read, SPI byte) or a load of raw
// 24-bit temperature and pressure values, and yields exactly one response
// that carries a read byte and a flag saying whether it is to be sent.
// A request is captured in an input register and resolved into a response
// register once that register is free or draining; the response is then
// presented from the response register until it is taken. One
// request is taken every cycle; the only limit is the response register,
// which holds while the response side stalls. The pointer and measurement
// registers are updated when a request is resolved, so back-to-back requests
// see each other's effects in order.
module pressure_sensor_register_file_top
	import psrf_pkg::*;
#(
	parameter int CALIB_WORDS = CALIB_WORDS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	psrf_chan_if.sink    req,
	psrf_chan_if.source  rsp
);

	// Last byte address of the calibration ROM, plus one.
	localparam logic [8:0] CALIB_END = 9'(CALIB_BASE) + 9'(2 * CALIB_WORDS);

	// Input register.
	req_t        req_s1;
	logic        valid_s1;

	// Sensor state.
	logic [7:0]  pointer_q;
	logic [23:0] temp_q;
	logic [23:0] press_q;
	logic        spi_read_q;

	// Response register.
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	// Next-state and read path signals.
	logic        advance;
	logic [7:0]  ptr_eff;
	logic        flag_eff;
	logic        do_read;
	logic        soft_reset;
	logic [7:0]  calib_off;
	logic [15:0] calib_w;
	logic [7:0]  rd_byte;
	logic [7:0]  pointer_d;

	// Resolve the held request when the response register is free or draining.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// An SPI command byte sets pointer and read flag before its own read.
	always_comb begin
		ptr_eff    = pointer_q;
		flag_eff   = spi_read_q;
		do_read    = 1'b0;
		soft_reset = 1'b0;
		case (req_s1.kind)
			KIND_I2C_WR: begin
				soft_reset = (req_s1.byte_index != I2C_PTR_POS) &&
					(pointer_q == RESET_ADDR) && (req_s1.data_byte == RESET_CODE);
			end
			KIND_I2C_RD: begin
				do_read = 1'b1;
			end
			KIND_SPI: begin
				if (req_s1.byte_index == SPI_CMD_POS) begin
					ptr_eff  = req_s1.data_byte | SPI_SET;
					flag_eff = req_s1.data_byte[7];
				end
				do_read = flag_eff && ((req_s1.byte_index == SPI_CMD_POS) ||
					(req_s1.byte_index == SPI_DAT_POS));
			end
			default: begin
			end
		endcase
	end

	// Register map read at the effective pointer.
	assign calib_off = ptr_eff - CALIB_BASE;
	assign calib_w   = calib_word(calib_off[4:1]);

	always_comb begin
		if (ptr_eff == ID_ADDR) begin
			rd_byte = ID_VALUE;
		end else if (ptr_eff == TEMP_MSB) begin
			rd_byte = temp_q[23:16];
		end else if (ptr_eff == TEMP_LSB) begin
			rd_byte = temp_q[15:8];
		end else if (ptr_eff == TEMP_XLSB) begin
			rd_byte = temp_q[7:0];
		end else if (ptr_eff == PRESS_MSB) begin
			rd_byte = press_q[23:16];
		end else if (ptr_eff == PRESS_LSB) begin
			rd_byte = press_q[15:8];
		end else if (ptr_eff == PRESS_XLSB) begin
			rd_byte = press_q[7:0];
		end else if ((ptr_eff >= CALIB_BASE) && ({1'b0, ptr_eff} < CALIB_END)) begin
			rd_byte = calib_off[0] ? calib_w[15:8] : calib_w[7:0];
		end else begin
			rd_byte = NO_REG;
		end
	end

	// Pointer update: an I2C write at the pointer position loads it, an SPI
	// command byte sets it, a read advances it with wraparound.
	always_comb begin
		pointer_d = ptr_eff;
		if (req_s1.kind == KIND_I2C_WR && req_s1.byte_index == I2C_PTR_POS) begin
			pointer_d = req_s1.data_byte;
		end else if (do_read) begin
			pointer_d = ptr_eff + 8'd1;
		end
	end

	// Input register; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.payload;
		end
	end

	// Sensor state. The control register has no read path in this map, so
	// writes to it leave nothing visible and are not stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q  <= '0;
			temp_q     <= '0;
			press_q    <= '0;
			spi_read_q <= 1'b0;
		end else if (advance) begin
			if (soft_reset) begin
				pointer_q  <= '0;
				temp_q     <= '0;
				press_q    <= '0;
				spi_read_q <= 1'b0;
			end else begin
				pointer_q  <= pointer_d;
				spi_read_q <= flag_eff;
				if (req_s1.kind == KIND_LOAD) begin
					temp_q  <= req_s1.temp_raw;
					press_q <= req_s1.press_raw;
				end
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data  <= do_read ? rd_byte : 8'd0;
			rsp_q.read_valid <= do_read;
		end
	end

endmodule

`default_nettype wire

// ===== design/psrf_checker.sv =====
// Port-level checker for the pressure sensor register file, and its bind.
// Depends on psrf_pkg and pressure_sensor_register_file_top.
`default_nettype none

module psrf_checker
	import psrf_pkg::*;
(
	input wire  clk,
	input wire  arst_n,
	input wire  req_valid,
	input wire  req_ready,
	input wire  rsp_valid,
	input wire  rsp_ready,
	input rsp_t rsp_payload
);

	// A stalled response keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled response changed");

	// A response without a read byte carries zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_payload.read_valid |-> rsp_payload.read_data == 8'd0)
		else $error("unused read data not zero");

	// Requests are only held off while a response waits to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without response backpressure");

	// No response is offered during reset.
	assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind pressure_sensor_register_file_top psrf_checker u_psrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire
